// ===== rtl/nlt_pkg.sv =====
package nlt_pkg;

	localparam int TABLE_SLOTS_DEF = 16;
	localparam int MAX_EVENTS      = 16;
	localparam int EVT_CNT_W       = $clog2(MAX_EVENTS + 1);
	localparam int MAC_W           = 48;
	localparam int TIME_W          = 32;
	localparam int SLOT_W          = 4;
	localparam int CFG_IDX_W       = 1;

	localparam logic [TIME_W-1:0] RST_OFFLINE_TIMEOUT = TIME_W'(10000);
	localparam logic [TIME_W-1:0] RST_CHECK_PERIOD    = TIME_W'(1000);

	localparam logic [CFG_IDX_W-1:0] CFG_OFFLINE_TIMEOUT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHECK_PERIOD    = 1'b1;

	localparam logic OP_PACKET = 1'b0;
	localparam logic OP_CHECK  = 1'b1;

	typedef enum logic [1:0] {
		EV_DISCOVERED = 2'd0,
		EV_ONLINE     = 2'd1,
		EV_OFFLINE    = 2'd2,
		EV_TABLE_FULL = 2'd3
	} ev_kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_P_LOOK,
		ST_P_CHK,
		ST_P_DISC,
		ST_P_ON,
		ST_P_FULL,
		ST_S_LOOK,
		ST_S_CHK,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic              opcode;
		logic [MAC_W-1:0]  sender_mac;
		logic [TIME_W-1:0] now_ms;
	} in_item_t;

	typedef struct packed {
		ev_kind_t          event_kind;
		logic [SLOT_W-1:0] slot_index;
		logic [MAC_W-1:0]  event_mac;
		logic [TIME_W-1:0] elapsed_ms;
		logic              last_event;
	} out_item_t;

	typedef struct packed {
		logic [MAC_W-1:0]  mac;
		logic [TIME_W-1:0] seen;
	} entry_t;

	typedef struct packed {
		logic [TIME_W-1:0] x;
		logic [TIME_W-1:0] y;
		logic [TIME_W-1:0] lim;
		logic [MAC_W-1:0]  mac_a;
		logic [MAC_W-1:0]  mac_b;
	} unit_in_t;

	typedef struct packed {
		logic [TIME_W-1:0] diff;
		logic              gt;
		logic              eq;
		logic              mac_eq;
	} unit_out_t;

endpackage

// ===== rtl/nlt_store.sv =====
module nlt_store import nlt_pkg::*; #(
	parameter int SLOTS = TABLE_SLOTS_DEF,
	parameter int IDX_W = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  entry_t           wdata,
	input  logic [IDX_W-1:0] raddr,
	output entry_t           rdata
);

	entry_t mem [SLOTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/nlt_unit.sv =====
module nlt_unit import nlt_pkg::*; (
	input  unit_in_t  u_in,
	output unit_out_t u_out
);

	always_comb begin
		u_out.diff   = u_in.x - u_in.y;
		u_out.gt     = u_out.diff > u_in.lim;
		u_out.eq     = u_out.diff == u_in.lim;
		u_out.mac_eq = u_in.mac_a == u_in.mac_b;
	end

endmodule

// ===== rtl/nlt_ctrl.sv =====
module nlt_ctrl import nlt_pkg::*; #(
	parameter int SLOTS = TABLE_SLOTS_DEF,
	parameter int IDX_W = 4,
	parameter int CNT_W = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TIME_W-1:0]    cfg_data,
	output logic                 mem_we,
	output logic [IDX_W-1:0]     mem_waddr,
	output entry_t               mem_wdata,
	output logic [IDX_W-1:0]     mem_raddr,
	input  entry_t               mem_rdata,
	output unit_in_t             u_in,
	input  unit_out_t            u_out
);

	state_t state_q, state_d;

	logic [CNT_W-1:0]     idx_q;
	logic [IDX_W-1:0]     free_idx_q;
	logic                 free_v_q;
	logic [EVT_CNT_W-1:0] cnt_q;
	logic [MAC_W-1:0]     mac_q;
	logic [TIME_W-1:0]    now_q;
	logic [TIME_W-1:0]    timeout_q;
	logic [TIME_W-1:0]    period_q;
	logic [TIME_W-1:0]    last_sweep_q;
	logic [SLOTS-1:0]     valid_q;
	logic [SLOTS-1:0]     online_q;
	out_item_t            pend_q;
	logic                 pend_v_q;
	out_item_t            out_q;
	logic                 out_v_q;

	logic [IDX_W-1:0]    idx_s;
	logic [IDX_W+SLOT_W-1:0] idx_x;
	logic [IDX_W+SLOT_W-1:0] free_x;
	logic                idx_end;
	logic                out_free;
	logic                emit_ok;
	logic                in_acc;
	logic                sweep_start;
	logic                idx_inc;
	logic                free_set;
	logic                set_new;
	logic                set_on;
	logic                clr_on;
	logic                cnt_inc;
	logic                emit;
	logic                flush;
	out_item_t           ev;

	assign idx_s    = idx_q[IDX_W-1:0];
	assign idx_x    = {{SLOT_W{1'b0}}, idx_s};
	assign free_x   = {{SLOT_W{1'b0}}, free_idx_q};
	assign idx_end  = idx_q == CNT_W'(SLOTS);
	assign out_free = !out_v_q || !out_stall;
	assign emit_ok  = !pend_v_q || out_free;

	assign in_stall  = state_q != ST_IDLE;
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_v_q;
	assign out_data  = out_q;

	assign mem_raddr = idx_s;
	assign mem_waddr = (state_q == ST_P_DISC) ? free_idx_q : idx_s;
	assign mem_wdata = '{mac: mac_q, seen: now_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		sweep_start = 1'b0;
		idx_inc     = 1'b0;
		free_set    = 1'b0;
		set_new     = 1'b0;
		set_on      = 1'b0;
		clr_on      = 1'b0;
		cnt_inc     = 1'b0;
		emit        = 1'b0;
		flush       = 1'b0;
		mem_we      = 1'b0;
		ev          = '0;
		u_in.x      = now_q;
		u_in.y      = mem_rdata.seen;
		u_in.lim    = timeout_q;
		u_in.mac_a  = mac_q;
		u_in.mac_b  = mem_rdata.mac;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (in_data.opcode)
						OP_PACKET: state_d = ST_P_LOOK;
						OP_CHECK: begin
							u_in.x   = in_data.now_ms;
							u_in.y   = last_sweep_q;
							u_in.lim = period_q;
							if (u_out.gt || u_out.eq) begin
								sweep_start = 1'b1;
								state_d     = ST_S_LOOK;
							end
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_P_LOOK: begin
				if (idx_end) begin
					state_d = free_v_q ? ST_P_DISC : ST_P_FULL;
				end else begin
					state_d = ST_P_CHK;
				end
			end
			ST_P_CHK: begin
				if (valid_q[idx_s] && u_out.mac_eq) begin
					if (online_q[idx_s]) begin
						mem_we  = 1'b1;
						state_d = ST_FLUSH;
					end else if (emit_ok) begin
						mem_we        = 1'b1;
						set_on        = 1'b1;
						emit          = 1'b1;
						ev.event_kind = EV_ONLINE;
						ev.slot_index = idx_x[SLOT_W-1:0];
						ev.event_mac  = mac_q;
						state_d       = ST_FLUSH;
					end
				end else begin
					free_set = !valid_q[idx_s] && !free_v_q;
					idx_inc  = 1'b1;
					state_d  = ST_P_LOOK;
				end
			end
			ST_P_DISC: begin
				if (emit_ok) begin
					mem_we        = 1'b1;
					set_new       = 1'b1;
					emit          = 1'b1;
					ev.event_kind = EV_DISCOVERED;
					ev.slot_index = free_x[SLOT_W-1:0];
					ev.event_mac  = mac_q;
					state_d       = ST_P_ON;
				end
			end
			ST_P_ON: begin
				if (emit_ok) begin
					emit          = 1'b1;
					ev.event_kind = EV_ONLINE;
					ev.slot_index = free_x[SLOT_W-1:0];
					ev.event_mac  = mac_q;
					state_d       = ST_FLUSH;
				end
			end
			ST_P_FULL: begin
				if (emit_ok) begin
					emit          = 1'b1;
					ev.event_kind = EV_TABLE_FULL;
					ev.event_mac  = mac_q;
					state_d       = ST_FLUSH;
				end
			end
			ST_S_LOOK: begin
				if (idx_end || cnt_q == EVT_CNT_W'(MAX_EVENTS)) begin
					state_d = ST_FLUSH;
				end else begin
					state_d = ST_S_CHK;
				end
			end
			ST_S_CHK: begin
				if (valid_q[idx_s] && online_q[idx_s] && u_out.gt) begin
					if (emit_ok) begin
						clr_on        = 1'b1;
						emit          = 1'b1;
						ev.event_kind = EV_OFFLINE;
						ev.slot_index = idx_x[SLOT_W-1:0];
						ev.event_mac  = mem_rdata.mac;
						ev.elapsed_ms = u_out.diff;
						cnt_inc       = 1'b1;
						idx_inc       = 1'b1;
						state_d       = ST_S_LOOK;
					end
				end else begin
					idx_inc = 1'b1;
					state_d = ST_S_LOOK;
				end
			end
			ST_FLUSH: begin
				if (!pend_v_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					flush   = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			free_v_q     <= 1'b0;
			cnt_q        <= '0;
			timeout_q    <= RST_OFFLINE_TIMEOUT;
			period_q     <= RST_CHECK_PERIOD;
			last_sweep_q <= '0;
			valid_q      <= '0;
			online_q     <= '0;
			pend_v_q     <= 1'b0;
			out_v_q      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_OFFLINE_TIMEOUT: timeout_q <= cfg_data;
					CFG_CHECK_PERIOD:    period_q  <= cfg_data;
					default: ;
				endcase
			end
			if (in_acc) begin
				idx_q    <= '0;
				free_v_q <= 1'b0;
				cnt_q    <= '0;
			end
			if (sweep_start) begin
				last_sweep_q <= in_data.now_ms;
			end
			if (idx_inc) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (free_set) begin
				free_v_q <= 1'b1;
			end
			if (cnt_inc) begin
				cnt_q <= cnt_q + EVT_CNT_W'(1);
			end
			if (set_new) begin
				valid_q[free_idx_q]  <= 1'b1;
				online_q[free_idx_q] <= 1'b1;
			end
			if (set_on) begin
				online_q[idx_s] <= 1'b1;
			end
			if (clr_on) begin
				online_q[idx_s] <= 1'b0;
			end
			if ((emit && pend_v_q) || flush) begin
				out_v_q <= 1'b1;
			end else if (out_v_q && !out_stall) begin
				out_v_q <= 1'b0;
			end
			if (emit) begin
				pend_v_q <= 1'b1;
			end
			if (flush) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mac_q <= in_data.sender_mac;
			now_q <= in_data.now_ms;
		end
		if (free_set) begin
			free_idx_q <= idx_s;
		end
		if (emit) begin
			pend_q <= ev;
			if (pend_v_q) begin
				out_q <= {pend_q[$bits(out_item_t)-1:1], 1'b0};
			end
		end
		if (flush) begin
			out_q <= {pend_q[$bits(out_item_t)-1:1], 1'b1};
		end
	end

	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_v_q)
		else $error("pending event left behind in idle");

	a_online_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(online_q & ~valid_q) == '0)
		else $error("online mark on an invalid slot");

	a_we_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_P_CHK || state_q == ST_P_DISC))
		else $error("table write outside packet update");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_inc |-> (cnt_q < EVT_CNT_W'(MAX_EVENTS)))
		else $error("sweep event count overrun");

endmodule

// ===== rtl/node_liveness_table.sv =====
// Channel | Dir | Handshake          | Payload
// in      | in  | in_valid/in_stall  | in_data (in_item_t)
// out     | out | out_valid/out_stall| out_data (out_item_t)
// cfg     | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Packet: walks the slots (registered table read) until the sender matches or the table ends.
// Check: no walk when no sweep is due, else walks the slots until the end or MAX_EVENTS events; one item at a time.
// Reset clears valid/online marks, sweep time and registers at once; no clearing pass.
// A stalled output holds one beat in the output register and one pending beat; the walk waits.
module node_liveness_table import nlt_pkg::*; #(
	parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TIME_W-1:0]    cfg_data
);

	localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int CNT_W = $clog2(TABLE_SLOTS + 1);

	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	entry_t           mem_wdata;
	logic [IDX_W-1:0] mem_raddr;
	entry_t           mem_rdata;
	unit_in_t         u_in;
	unit_out_t        u_out;

	nlt_ctrl #(
		.SLOTS (TABLE_SLOTS),
		.IDX_W (IDX_W),
		.CNT_W (CNT_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.u_in      (u_in),
		.u_out     (u_out)
	);

	nlt_store #(
		.SLOTS (TABLE_SLOTS),
		.IDX_W (IDX_W)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	nlt_unit u_unit (
		.u_in  (u_in),
		.u_out (u_out)
	);

endmodule

// ===== test/liveness_checker.sv =====
module liveness_checker import nlt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  in_item_t             in_data,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  out_item_t            out_data,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TIME_W-1:0]    cfg_data,
	output int                   fails,
	output int                   backlog
);

	localparam int SLOTS = TABLE_SLOTS_DEF;

	logic [MAC_W-1:0]  slot_mac    [SLOTS];
	logic [TIME_W-1:0] slot_seen   [SLOTS];
	bit                slot_online [SLOTS];
	bit                slot_used   [SLOTS];
	logic [TIME_W-1:0] swept_at;
	logic [TIME_W-1:0] timeout_ms;
	logic [TIME_W-1:0] period_ms;
	out_item_t         pending_events[$];

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		if (fails < 200) begin
			$display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
		end
		fails++;
	endtask

	function automatic out_item_t make_event(ev_kind_t kind, int slot,
			logic [MAC_W-1:0] mac, logic [TIME_W-1:0] elapsed);
		out_item_t ev;
		ev.event_kind = kind;
		ev.slot_index = SLOT_W'(slot);
		ev.event_mac  = mac;
		ev.elapsed_ms = elapsed;
		ev.last_event = 1'b0;
		return ev;
	endfunction

	task automatic clear_table();
		for (int i = 0; i < SLOTS; i++) begin
			slot_mac[i]    = '0;
			slot_seen[i]   = '0;
			slot_online[i] = 1'b0;
			slot_used[i]   = 1'b0;
		end
		swept_at   = '0;
		timeout_ms = RST_OFFLINE_TIMEOUT;
		period_ms  = RST_CHECK_PERIOD;
	endtask

	// learn the sender or age the table, queueing the events this beat causes
	task automatic track_item(in_item_t it);
		int hit;
		int first;
		logic [TIME_W-1:0] since;
		logic [TIME_W-1:0] idle;
		hit   = -1;
		first = pending_events.size();
		if (it.opcode == OP_PACKET) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (hit < 0 && slot_used[i] && slot_mac[i] == it.sender_mac) hit = i;
			end
			if (hit < 0) begin
				for (int i = 0; i < SLOTS; i++) begin
					if (hit < 0 && !slot_used[i]) hit = i;
				end
				if (hit < 0) begin
					pending_events.push_back(make_event(EV_TABLE_FULL, 0, it.sender_mac, '0));
				end else begin
					slot_mac[hit]    = it.sender_mac;
					slot_used[hit]   = 1'b1;
					slot_online[hit] = 1'b0;
					pending_events.push_back(make_event(EV_DISCOVERED, hit, it.sender_mac, '0));
				end
			end
			if (hit >= 0) begin
				slot_seen[hit] = it.now_ms;
				if (!slot_online[hit]) begin
					slot_online[hit] = 1'b1;
					pending_events.push_back(make_event(EV_ONLINE, hit, it.sender_mac, '0));
				end
			end
		end else begin
			since = it.now_ms - swept_at;
			if (since >= period_ms) begin
				swept_at = it.now_ms;
				for (int i = 0; i < SLOTS; i++) begin
					idle = it.now_ms - slot_seen[i];
					if (slot_used[i] && slot_online[i] && idle > timeout_ms &&
							pending_events.size() - first < MAX_EVENTS) begin
						slot_online[i] = 1'b0;
						pending_events.push_back(make_event(EV_OFFLINE, i, slot_mac[i], idle));
					end
				end
			end
		end
		if (pending_events.size() > first) begin
			pending_events[pending_events.size() - 1].last_event = 1'b1;
		end
	endtask

	task automatic compare_event(out_item_t got);
		out_item_t want;
		if (pending_events.size() == 0) begin
			report("unexpected event", 64'(got.event_mac), '0);
			return;
		end
		want = pending_events.pop_front();
		if (got.event_kind !== want.event_kind)
			report("event_kind", 64'(got.event_kind), 64'(want.event_kind));
		if (got.slot_index !== want.slot_index)
			report("slot_index", 64'(got.slot_index), 64'(want.slot_index));
		if (got.event_mac !== want.event_mac)
			report("event_mac", 64'(got.event_mac), 64'(want.event_mac));
		if (got.elapsed_ms !== want.elapsed_ms)
			report("elapsed_ms", 64'(got.elapsed_ms), 64'(want.elapsed_ms));
		if (got.last_event !== want.last_event)
			report("last_event", 64'(got.last_event), 64'(want.last_event));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_table();
			pending_events.delete();
			fails   = 0;
			backlog <= 0;
		end else begin
			if (out_valid && !out_stall) compare_event(out_data);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_OFFLINE_TIMEOUT: timeout_ms = cfg_data;
					CFG_CHECK_PERIOD:    period_ms  = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) track_item(in_data);
			backlog <= pending_events.size();
		end
	end

endmodule

// ===== test/node_liveness_table_tb.sv =====
module node_liveness_table_tb;
	import nlt_pkg::*;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	in_item_t             in_data   = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_item_t            out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [TIME_W-1:0]    cfg_data  = '0;
	int                   fails;
	int                   backlog;

	bit                tx_gaps;
	bit                rx_gaps;
	logic              hold_armed = 1'b0;
	bit                hold_done;
	logic [MAC_W-1:0]  roster [TABLE_SLOTS_DEF];
	logic [TIME_W-1:0] clock_ms;

	node_liveness_table dut (.*);

	liveness_checker chk (.*);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	initial begin
		#(12 * 600000);
		$display("TEST FAILED");
		$finish;
	end

	// receiver: random stall bursts, plus one long hold-off
	initial begin
		forever begin
			@(posedge clk);
			if (hold_armed && !hold_done) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				out_stall <= 1'b0;
			end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic offer(in_item_t it);
		if (tx_gaps && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic packet(logic [MAC_W-1:0] mac, logic [TIME_W-1:0] now);
		in_item_t it;
		it.opcode     = OP_PACKET;
		it.sender_mac = mac;
		it.now_ms     = now;
		offer(it);
	endtask

	task automatic sweep(logic [TIME_W-1:0] now);
		in_item_t it;
		it.opcode     = OP_CHECK;
		it.sender_mac = MAC_W'({$urandom, $urandom});
		it.now_ms     = now;
		offer(it);
	endtask

	task automatic set_regs(logic [TIME_W-1:0] timeout, logic [TIME_W-1:0] period);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_OFFLINE_TIMEOUT;
		cfg_data  <= timeout;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= CFG_CHECK_PERIOD;
		cfg_data  <= period;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// drain all events, then cover a walk that produces nothing
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (backlog != 0) @(posedge clk);
		repeat (2 * TABLE_SLOTS_DEF + 8) @(posedge clk);
	endtask

	task automatic random_run(int count, int step_max, bit gaps);
		in_item_t it;
		for (int k = 0; k < count; k++) begin
			if (k % 32 == 0) begin
				tx_gaps = gaps && $urandom_range(0, 2) != 0;
				rx_gaps = gaps && $urandom_range(0, 2) != 0;
			end
			if ($urandom_range(0, 39) == 0) clock_ms = $urandom;
			else clock_ms += $urandom_range(0, step_max);
			it.now_ms     = clock_ms;
			it.sender_mac = MAC_W'({$urandom, $urandom});
			it.opcode     = ($urandom_range(0, 3) == 0) ? OP_CHECK : OP_PACKET;
			if (it.opcode == OP_PACKET && $urandom_range(0, 7) != 0) begin
				it.sender_mac = roster[$urandom_range(0, TABLE_SLOTS_DEF - 1)];
			end
			offer(it);
		end
	endtask

	initial begin
		roster[0] = '0;
		roster[1] = '1;
		for (int i = 2; i < TABLE_SLOTS_DEF; i++) roster[i] = MAC_W'({$urandom, $urandom});
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_regs(32'd100, 32'd50);
		packet(roster[0], 32'd0);
		packet(roster[1], '1);
		packet(roster[0], 32'd10);
		sweep(32'd20);
		sweep(32'd60);
		sweep(32'd110);
		sweep(32'd300);
		packet(roster[0], 32'd310);
		packet(roster[1], 32'd320);
		for (int i = 2; i < TABLE_SLOTS_DEF; i++) packet(roster[i], 32'd400 + i);
		packet(MAC_W'({$urandom, $urandom}), 32'd500);
		sweep(32'd100000);
		clock_ms = 32'd100000;
		settle();

		set_regs(32'd500, 32'd100);
		random_run(110, 200, 1'b1);
		settle();

		set_regs('0, '0);
		random_run(60, 3, 1'b1);
		settle();

		set_regs('1, '1);
		random_run(40, 1000, 1'b1);
		settle();

		set_regs(32'd1000, 32'd300);
		hold_armed <= 1'b1;
		random_run(50, 400, 1'b1);
		settle();

		set_regs(RST_OFFLINE_TIMEOUT, RST_CHECK_PERIOD);
		random_run(90, 2000, 1'b0);
		settle();

		if (fails == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/nlt_pkg.sv
rtl/nlt_store.sv
rtl/nlt_unit.sv
rtl/nlt_ctrl.sv
rtl/node_liveness_table.sv
test/liveness_checker.sv
test/node_liveness_table_tb.sv
